// ===== design/dsst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dsst_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_M_FRONT        = 3'd0,
        REG_M_CENTER       = 3'd1,
        REG_CENTER_ENABLED = 3'd2,
        REG_M_BACK         = 3'd3,
        REG_Y_CENTER       = 3'd4,
        REG_Y_FRONT        = 3'd5,
        REG_Y_BACK         = 3'd6,
        REG_SPREAD_SPEED   = 3'd7
    } t_reg_idx;

    // interpolation divide: |dM| * |dy| over |dY|
    localparam int DIV1_DW = 47;
    localparam int DIV1_VW = 32;
    // source divide: |M| * speed * 2^11 over width
    localparam int DIV2_DW = 62;
    localparam int DIV2_VW = 32;

    localparam logic signed [50:0] RHS_MAX = 51'sd140737488355327;
    localparam logic signed [50:0] RHS_MIN = -51'sd140737488355328;
    localparam logic signed [48:0] M_LIMIT = 49'sd1048576;

    typedef struct packed {
        logic               zone;
        logic               cst;
        logic               fault;
        logic               neg;
        logic [14:0]        ma;
        logic [31:0]        width;
        logic [16:0]        wsum;
        logic signed [47:0] rhs;
    } t_side1;

    typedef struct packed {
        logic               zone;
        logic               fault;
        logic               mneg;
        logic [16:0]        wsum;
        logic signed [47:0] rhs;
    } t_side2;

endpackage
`default_nettype wire

// ===== design/dsst_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dsst_div_cell #(
    parameter int DW = 8,
    parameter int VW = 8,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire logic [VW-1:0] i_rem,
    input  wire logic [DW-1:0] i_acc,
    input  wire logic [VW-1:0] i_dvs,
    input  wire logic [SW-1:0] i_side,
    output logic               o_vld,
    output logic      [VW-1:0] o_rem,
    output logic      [DW-1:0] o_acc,
    output logic      [VW-1:0] o_dvs,
    output logic      [SW-1:0] o_side
);
    logic [VW:0]   t;
    logic [VW:0]   d;
    logic          ge;
    logic [VW-1:0] n_rem;

    // shift in the next dividend bit, subtract if it fits
    always_comb begin
        t     = {i_rem, i_acc[DW-1]};
        d     = t - {1'b0, i_dvs};
        ge    = (t >= {1'b0, i_dvs});
        n_rem = ge ? d[VW-1:0] : t[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rem  <= n_rem;
        o_acc  <= {i_acc[DW-2:0], ge};
        o_dvs  <= i_dvs;
        o_side <= i_side;
    end
endmodule
`default_nettype wire

// ===== design/dsst_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dsst_div #(
    parameter int DW = 8,
    parameter int VW = 8,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    input  wire logic [SW-1:0] i_side,
    output logic               o_vld,
    output logic      [DW-1:0] o_quot,
    output logic      [SW-1:0] o_side
);
    logic          vld  [DW+1];
    logic [VW-1:0] rem  [DW+1];
    logic [DW-1:0] acc  [DW+1];
    logic [VW-1:0] dvs  [DW+1];
    logic [SW-1:0] side [DW+1];

    assign vld[0]  = i_vld;
    assign rem[0]  = '0;
    assign acc[0]  = i_dividend;
    assign dvs[0]  = i_divisor;
    assign side[0] = i_side;

    // one quotient bit per cell, MSB first
    for (genvar k = 0; k < DW; k++) begin : g_cell
        dsst_div_cell #(.DW(DW), .VW(VW), .SW(SW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (vld[k]),
            .i_rem  (rem[k]),
            .i_acc  (acc[k]),
            .i_dvs  (dvs[k]),
            .i_side (side[k]),
            .o_vld  (vld[k+1]),
            .o_rem  (rem[k+1]),
            .o_acc  (acc[k+1]),
            .o_dvs  (dvs[k+1]),
            .o_side (side[k+1])
        );
    end

    assign o_vld  = vld[DW];
    assign o_quot = acc[DW];
    assign o_side = side[DW];
endmodule
`default_nettype wire

// ===== design/dike_spreading_source_term_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One grid cell per clock: a beat is taken whenever start is high (busy stays low) and
// its result comes out at the end of the pipeline for a single cycle with o_valid high; the receiver
// cannot stall, so it must take every result beat as it comes. The pipeline runs through two
// rows of restoring divider cells, 47 for the opening-factor interpolation and 62 for the
// source divide by the dike width, plus seven pipeline stages around them. Configuration
// writes take effect at once and must only happen while no beat is in flight.
module dike_spreading_source_term_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_cfg_we,
    input  wire logic [dsst_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [dsst_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic [15:0]                      i_dike_fraction,
    input  wire logic [15:0]                      i_air_fraction,
    input  wire logic signed [31:0]               i_left_bound,
    input  wire logic signed [31:0]               i_right_bound,
    input  wire logic signed [31:0]               i_cell_y,
    input  wire logic signed [47:0]               i_rhs_in,
    output logic                                  o_valid,
    output logic signed [47:0]                    o_rhs_out,
    output logic                                  o_in_zone,
    output logic                                  o_divide_fault,
    output logic                                  o_saturated
);
    import dsst_pkg::*;

    localparam int SW1 = $bits(t_side1);
    localparam int SW2 = $bits(t_side2);

    // configuration
    logic [14:0]        r_m_front, r_m_center, r_m_back;
    logic               r_center_en;
    logic signed [31:0] r_y_center, r_y_front, r_y_back;
    logic [30:0]        r_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_front   <= 15'd16384;
            r_m_center  <= 15'd0;
            r_center_en <= 1'b0;
            r_m_back    <= 15'd16384;
            r_y_center  <= 32'sd0;
            r_y_front   <= 32'sd0;
            r_y_back    <= 32'sd65536;
            r_speed     <= 31'd0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_M_FRONT:        r_m_front   <= i_cfg_data[14:0];
                REG_M_CENTER:       r_m_center  <= i_cfg_data[14:0];
                REG_CENTER_ENABLED: r_center_en <= i_cfg_data[0];
                REG_M_BACK:         r_m_back    <= i_cfg_data[14:0];
                REG_Y_CENTER:       r_y_center  <= i_cfg_data;
                REG_Y_FRONT:        r_y_front   <= i_cfg_data;
                REG_Y_BACK:         r_y_back    <= i_cfg_data;
                REG_SPREAD_SPEED:   r_speed     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: zone test and profile segment select
    logic [14:0]        ma, mb;
    logic signed [31:0] ya, yb;
    logic [32:0]        wdiff;
    logic               n1_zone, n1_cst;

    always_comb begin
        n1_zone = (i_dike_fraction != 16'd0) && (i_right_bound > i_left_bound);
        n1_cst  = !r_center_en && (r_m_front == r_m_back);
        ma = r_m_front;
        mb = r_m_back;
        ya = r_y_front;
        yb = r_y_back;
        if (r_center_en) begin
            if (i_cell_y >= r_y_center) begin
                ma = r_m_center;
                ya = r_y_center;
            end else begin
                mb = r_m_center;
                yb = r_y_center;
            end
        end
        wdiff = {i_right_bound[31], i_right_bound} - {i_left_bound[31], i_left_bound};
    end

    logic               r1_vld, r1_zone, r1_cst;
    logic [14:0]        r1_ma;
    logic signed [15:0] r1_dm;
    logic signed [32:0] r1_dy, r1_den;
    logic [31:0]        r1_width;
    logic [16:0]        r1_wsum;
    logic signed [47:0] r1_rhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_zone  <= n1_zone;
        r1_cst   <= n1_cst;
        r1_ma    <= ma;
        r1_dm    <= $signed({1'b0, mb}) - $signed({1'b0, ma});
        r1_dy    <= $signed({i_cell_y[31], i_cell_y}) - $signed({ya[31], ya});
        r1_den   <= $signed({yb[31], yb}) - $signed({ya[31], ya});
        r1_width <= wdiff[31:0];
        r1_wsum  <= {1'b0, i_dike_fraction} + {1'b0, i_air_fraction};
        r1_rhs   <= i_rhs_in;
    end

    // stage 2: magnitudes and interpolation product
    logic [15:0] dm_abs;
    logic [32:0] dy_abs, den_abs;
    t_side1      n2_side;

    always_comb begin
        dm_abs  = r1_dm[15] ? 16'(-r1_dm) : 16'(r1_dm);
        dy_abs  = r1_dy[32] ? 33'(-r1_dy) : 33'(r1_dy);
        den_abs = r1_den[32] ? 33'(-r1_den) : 33'(r1_den);
        n2_side.zone  = r1_zone;
        n2_side.cst   = r1_cst;
        n2_side.fault = !r1_cst && (r1_den == 33'sd0);
        n2_side.neg   = r1_dm[15] ^ r1_dy[32] ^ r1_den[32];
        n2_side.ma    = r1_ma;
        n2_side.width = r1_width;
        n2_side.wsum  = r1_wsum;
        n2_side.rhs   = r1_rhs;
    end

    logic               r2_vld;
    logic [DIV1_DW-1:0] r2_num;
    logic [DIV1_VW-1:0] r2_den;
    t_side1             r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_num  <= DIV1_DW'(dm_abs[14:0] * dy_abs[31:0]);
        r2_den  <= den_abs[DIV1_VW-1:0];
        r2_side <= n2_side;
    end

    logic               d1_vld;
    logic [DIV1_DW-1:0] d1_quot;
    logic [SW1-1:0]     d1_side_bits;
    t_side1             d1_side;

    dsst_div #(.DW(DIV1_DW), .VW(DIV1_VW), .SW(SW1)) u_div_interp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (r2_vld),
        .i_dividend(r2_num),
        .i_divisor (r2_den),
        .i_side    (r2_side),
        .o_vld     (d1_vld),
        .o_quot    (d1_quot),
        .o_side    (d1_side_bits)
    );

    assign d1_side = t_side1'(d1_side_bits);

    // stage 3: opening factor, clamped
    logic signed [48:0] q_s, m_s;
    logic [20:0]        n3_mag;
    logic               n3_neg;

    always_comb begin
        q_s = d1_side.neg ? -$signed({2'b00, d1_quot}) : $signed({2'b00, d1_quot});
        m_s = q_s + $signed({34'd0, d1_side.ma});
        if (m_s > M_LIMIT) begin
            m_s = M_LIMIT;
        end else if (m_s < -M_LIMIT) begin
            m_s = -M_LIMIT;
        end
        if (d1_side.cst) begin
            m_s = $signed({34'd0, d1_side.ma});
        end
        n3_neg = m_s[48];
        n3_mag = n3_neg ? 21'(-m_s) : 21'(m_s);
    end

    logic        r3_vld;
    logic [20:0] r3_mag;
    t_side2      r3_side;
    logic [31:0] r3_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_mag        <= n3_mag;
        r3_width      <= d1_side.width;
        r3_side.zone  <= d1_side.zone;
        r3_side.fault <= d1_side.fault;
        r3_side.mneg  <= n3_neg;
        r3_side.wsum  <= d1_side.wsum;
        r3_side.rhs   <= d1_side.rhs;
    end

    // stage 4: |M| * speed, doubled and scaled by 2^10 on entry to the divider
    logic        r4_vld;
    logic [51:0] r4_prod;
    logic [31:0] r4_width;
    t_side2      r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_prod  <= r3_mag * r_speed;
        r4_width <= r3_width;
        r4_side  <= r3_side;
    end

    logic               d2_vld;
    logic [DIV2_DW-1:0] d2_quot;
    logic [SW2-1:0]     d2_side_bits;
    t_side2             d2_side;

    dsst_div #(.DW(DIV2_DW), .VW(DIV2_VW), .SW(SW2)) u_div_source (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (r4_vld),
        .i_dividend({r4_prod[50:0], 11'd0}),
        .i_divisor (r4_width),
        .i_side    (r4_side),
        .o_vld     (d2_vld),
        .o_quot    (d2_quot),
        .o_side    (d2_side_bits)
    );

    assign d2_side = t_side2'(d2_side_bits);

    // stage 5: weight by the fraction sum, split in high and low words
    logic        r5_vld;
    logic [46:0] r5_hw;
    logic [48:0] r5_lw;
    t_side2      r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_hw   <= d2_quot[61:32] * d2_side.wsum;
        r5_lw   <= d2_quot[31:0] * d2_side.wsum;
        r5_side <= d2_side;
    end

    // stage 6: contribution magnitude
    logic        r6_vld, r6_ovf;
    logic [49:0] r6_cmag;
    t_side2      r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_ovf  <= |r5_hw[46:32];
        r6_cmag <= {1'b0, r5_hw[31:0], 17'd0} + {16'd0, r5_lw[48:15]};
        r6_side <= r5_side;
    end

    // stage 7: accumulate and clip
    logic signed [50:0] sum;
    logic signed [47:0] n_rhs;
    logic               n_sat;

    always_comb begin
        sum = r6_side.mneg ? ($signed({{3{r6_side.rhs[47]}}, r6_side.rhs})
                              - $signed({1'b0, r6_cmag}))
                           : ($signed({{3{r6_side.rhs[47]}}, r6_side.rhs})
                              + $signed({1'b0, r6_cmag}));
        n_sat = 1'b0;
        n_rhs = sum[47:0];
        if (!r6_side.zone || r6_side.fault) begin
            n_rhs = r6_side.rhs;
        end else if (r6_ovf) begin
            n_sat = 1'b1;
            n_rhs = r6_side.mneg ? RHS_MIN[47:0] : RHS_MAX[47:0];
        end else if (sum > RHS_MAX) begin
            n_sat = 1'b1;
            n_rhs = RHS_MAX[47:0];
        end else if (sum < RHS_MIN) begin
            n_sat = 1'b1;
            n_rhs = RHS_MIN[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rhs_out      <= n_rhs;
        o_in_zone      <= r6_side.zone;
        o_divide_fault <= r6_side.zone && r6_side.fault;
        o_saturated    <= n_sat;
    end
endmodule
`default_nettype wire
